### hdl/tun_pkg.sv
// shared constants for the triangle unit normal pipeline
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 30;
    localparam int NORM_W               = 32;
endpackage
`default_nettype wire

### hdl/triangle_unit_normal_unit.sv
// triangle face unit normal: edges, cross product, exact rounded normalization
//
// input channel: i_valid / o_stall with the nine vertex coordinates of one
// triangle (signed, COORD_BITS each). a word is taken at a clock edge with
// i_valid high and o_stall low. output channel: o_valid / i_stall with the
// normal components o_nx, o_ny, o_nz (signed, NORMAL_FRAC_BITS fraction bits)
// and o_degenerate, set with a zero normal when the cross product is zero.
// throughput is one triangle per cycle while i_stall stays low. the pipeline
// has seven stages for edges, cross product and squared length, one
// digit-recurrence stage for each of the NORMAL_FRAC_BITS + 2 bits of the
// normalized magnitude, and the output register. every stage holds when it
// is full and the one after it holds, so a stall on i_stall fills the
// bubbles first and only then raises o_stall. a synchronous reset clears
// all valid bits; nothing else needs clearing.
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal_unit #(
    parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [COORD_BITS-1:0]       i_ax,
    input  wire logic signed [COORD_BITS-1:0]       i_ay,
    input  wire logic signed [COORD_BITS-1:0]       i_az,
    input  wire logic signed [COORD_BITS-1:0]       i_bx,
    input  wire logic signed [COORD_BITS-1:0]       i_by_coord,
    input  wire logic signed [COORD_BITS-1:0]       i_bz,
    input  wire logic signed [COORD_BITS-1:0]       i_cx,
    input  wire logic signed [COORD_BITS-1:0]       i_cy,
    input  wire logic signed [COORD_BITS-1:0]       i_cz,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [tun_pkg::NORM_W-1:0]       o_nx,
    output logic signed [tun_pkg::NORM_W-1:0]       o_ny,
    output logic signed [tun_pkg::NORM_W-1:0]       o_nz,
    output logic                                    o_degenerate
);
    import tun_pkg::*;

    localparam int EW  = COORD_BITS + 1;            // edge width
    localparam int PW  = 2 * EW;                    // product / magnitude width
    localparam int SW  = 4 * EW;                    // squared width
    localparam int YW  = NORMAL_FRAC_BITS + 2;      // root digits
    localparam int TW  = SW + NORMAL_FRAC_BITS + 8; // recurrence width
    localparam int SQ0 = 7;                         // first recurrence stage
    localparam int NS  = SQ0 + YW + 1;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;
    logic [NS-1:0] n_vld;

    // stage registers
    logic signed [EW-1:0] r_e   [3];
    logic signed [EW-1:0] r_f   [3];
    logic signed [PW-1:0] r_p   [3];
    logic signed [PW-1:0] r_q   [3];
    logic signed [PW:0]   r_n   [3];
    logic [PW-1:0]        r_mag [3];
    logic [2:0]           r_neg3;
    logic [PW-1:0]        r_hh  [3];
    logic [PW-1:0]        r_hl  [3];
    logic [PW-1:0]        r_ll  [3];
    logic [2:0]           r_neg4;
    logic                 r_deg4;
    logic [SW-1:0]        r_c2  [3];
    logic [2:0]           r_neg5;
    logic                 r_deg5;
    logic [SW-1:0]        r_c2b [3];
    logic [SW-1:0]        r_s6;
    logic [SW+1:0]        r_s36;
    logic [2:0]           r_neg6;
    logic                 r_deg6;

    logic [TW-1:0]        r_rr  [YW][3];
    logic [TW-1:0]        r_tt  [YW][3];
    logic [YW-1:0]        r_yy  [YW][3];
    logic [SW-1:0]        r_ss  [YW];
    logic [SW+1:0]        r_ss3 [YW];
    logic [2:0]           r_nn  [YW];
    logic                 r_dd  [YW];

    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;
    logic                     r_deg_o;

    // handshake: a stage loads when empty or when the next one moves
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = {r_vld[NS-2:0], i_valid};
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // stage 0: edges
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_e[0] <= EW'(i_bx) - EW'(i_ax);
            r_e[1] <= EW'(i_by_coord) - EW'(i_ay);
            r_e[2] <= EW'(i_bz) - EW'(i_az);
            r_f[0] <= EW'(i_cx) - EW'(i_ax);
            r_f[1] <= EW'(i_cy) - EW'(i_ay);
            r_f[2] <= EW'(i_cz) - EW'(i_az);
        end
    end

    // stage 1: cross product terms
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_p[0] <= PW'(r_e[1]) * PW'(r_f[2]);
            r_q[0] <= PW'(r_e[2]) * PW'(r_f[1]);
            r_p[1] <= PW'(r_e[2]) * PW'(r_f[0]);
            r_q[1] <= PW'(r_e[0]) * PW'(r_f[2]);
            r_p[2] <= PW'(r_e[0]) * PW'(r_f[1]);
            r_q[2] <= PW'(r_e[1]) * PW'(r_f[0]);
        end
    end

    // stage 2: cross product
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= (PW+1)'(r_p[i]) - (PW+1)'(r_q[i]);
            end
        end
    end

    // stage 3: sign and magnitude
    logic signed [PW:0] n_abs [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_abs[i] = r_n[i][PW] ? -r_n[i] : r_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i]  <= n_abs[i][PW-1:0];
                r_neg3[i] <= r_n[i][PW];
            end
        end
    end

    // stage 4: partial products of the squares
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= PW'(r_mag[i][PW-1:EW]) * PW'(r_mag[i][PW-1:EW]);
                r_hl[i] <= PW'(r_mag[i][PW-1:EW]) * PW'(r_mag[i][EW-1:0]);
                r_ll[i] <= PW'(r_mag[i][EW-1:0]) * PW'(r_mag[i][EW-1:0]);
            end
            r_neg4 <= r_neg3;
            r_deg4 <= (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
        end
    end

    // stage 5: component squares
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                r_c2[i] <= (SW'(r_hh[i]) << PW) + (SW'(r_hl[i]) << (EW + 1))
                         + SW'(r_ll[i]);
            end
            r_neg5 <= r_neg4;
            r_deg5 <= r_deg4;
        end
    end

    // stage 6: squared length and its triple
    logic [SW-1:0] n_s;
    assign n_s = r_c2[0] + r_c2[1] + r_c2[2];

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6   <= n_s;
            r_s36  <= (SW+2)'(n_s) + ((SW+2)'(n_s) << 1);
            r_c2b  <= r_c2;
            r_neg6 <= r_neg5;
            r_deg6 <= r_deg5;
        end
    end

    // root digit recurrence: largest y with y^2 * s <= c^2 * 4^(frac+1)
    // r is the scaled remainder, t = 4p + s with p the scaled partial y * s
    for (genvar j = 0; j < YW; j++) begin : g_sq
        logic [TW-1:0] a_r  [3];
        logic [TW-1:0] a_t  [3];
        logic [YW-1:0] a_y  [3];
        logic [SW-1:0] a_s;
        logic [SW+1:0] a_s3;
        logic [2:0]    a_n;
        logic          a_d;
        logic          ge   [3];
        logic [TW-1:0] rem  [3];
        logic [TW-1:0] tnx  [3];

        if (j == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    a_r[i] = TW'(r_c2b[i]);
                    a_t[i] = TW'(r_s6);
                    a_y[i] = '0;
                end
                a_s  = r_s6;
                a_s3 = r_s36;
                a_n  = r_neg6;
                a_d  = r_deg6;
            end
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    a_r[i] = r_rr[j-1][i];
                    a_t[i] = r_tt[j-1][i];
                    a_y[i] = r_yy[j-1][i];
                end
                a_s  = r_ss[j-1];
                a_s3 = r_ss3[j-1];
                a_n  = r_nn[j-1];
                a_d  = r_dd[j-1];
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                ge[i]  = a_r[i] >= a_t[i];
                rem[i] = ge[i] ? (a_r[i] - a_t[i]) : a_r[i];
                tnx[i] = ge[i] ? ((a_t[i] << 1) + TW'(a_s3))
                               : ((a_t[i] << 1) - TW'(a_s));
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[SQ0+j]) begin
                for (int i = 0; i < 3; i++) begin
                    r_rr[j][i] <= rem[i] << 2;
                    r_tt[j][i] <= tnx[i];
                    r_yy[j][i] <= {a_y[i][YW-2:0], ge[i]};
                end
                r_ss[j]  <= a_s;
                r_ss3[j] <= a_s3;
                r_nn[j]  <= a_n;
                r_dd[j]  <= a_d;
            end
        end
    end

    // output: round y to m = (y + 1) / 2, apply sign
    logic [YW:0]       n_m  [3];
    logic [NORM_W-1:0] n_o  [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m[i] = ((YW+1)'(r_yy[YW-1][i]) + (YW+1)'(1)) >> 1;
            if (r_dd[YW-1]) begin
                n_o[i] = '0;
            end else if (r_nn[YW-1][i]) begin
                n_o[i] = NORM_W'(0) - NORM_W'(n_m[i][YW-1:0]);
            end else begin
                n_o[i] = NORM_W'(n_m[i][YW-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_nx    <= n_o[0];
            r_ny    <= n_o[1];
            r_nz    <= n_o[2];
            r_deg_o <= r_dd[YW-1];
        end
    end

    assign o_nx         = r_nx;
    assign o_ny         = r_ny;
    assign o_nz         = r_nz;
    assign o_degenerate = r_deg_o;
endmodule
`default_nettype wire

### test/tb_triangle_unit_normal_unit.sv
// testbench for the triangle unit normal unit: directed table, then random triangles
`timescale 1ns / 1ps
module tb_triangle_unit_normal_unit;
    import tun_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int FB = NORMAL_FRAC_BITS_DEF;
    localparam logic signed [NORM_W-1:0] UNIT = 1 <<< FB;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam int N_RANDOM = 2000;
    localparam int DRAIN_CYCLES = FB + 30;

    // vertex order: ax ay az bx by bz cx cy cz, element 0 is ax
    typedef logic [0:8][CW-1:0] tri_t;
    typedef struct {
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic                     degen;
    } normal_t;
    typedef struct {
        tri_t    v;
        logic    known;
        normal_t res;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    tri_t vin = '0;
    logic o_stall, o_valid, o_degenerate;
    logic signed [NORM_W-1:0] o_nx, o_ny, o_nz;

    normal_t pending_normals[$];
    int errors = 0;
    bit no_idle = 1'b0;
    bit took_word = 1'b0;
    int stall_left = 0;

    triangle_unit_normal_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_ax(vin[0]), .i_ay(vin[1]), .i_az(vin[2]),
        .i_bx(vin[3]), .i_by_coord(vin[4]), .i_bz(vin[5]),
        .i_cx(vin[6]), .i_cy(vin[7]), .i_cz(vin[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_nx(o_nx), .o_ny(o_ny), .o_nz(o_nz), .o_degenerate(o_degenerate)
    );

    always #1 i_clk = ~i_clk;

    // nearest integer to mag * 2^FB / sqrt(len2), ties away from zero
    function automatic logic [31:0] scaled_mag(logic [51:0] mag, logic [103:0] len2);
        logic [199:0] target, odd, prod, len_w;
        logic [31:0] lo, hi, mid;
        target = mag;
        target = (target * target) << (2 * FB + 2);
        len_w = len2;
        lo = 0;
        hi = 1 << FB;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 2 * mid - 1;
            prod = odd * odd * len_w;
            if (prod <= target) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic normal_t face_normal(tri_t v);
        logic signed [CW:0] e[3], f[3];
        logic signed [51:0] n[3];
        logic [51:0] m[3];
        logic [103:0] len2;
        logic [31:0] q[3];
        normal_t r;
        for (int i = 0; i < 3; i++) begin
            e[i] = $signed(v[3+i]) - $signed(v[i]);
            f[i] = $signed(v[6+i]) - $signed(v[i]);
        end
        n[0] = e[1] * f[2] - e[2] * f[1];
        n[1] = e[2] * f[0] - e[0] * f[2];
        n[2] = e[0] * f[1] - e[1] * f[0];
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = n[i] < 0 ? -n[i] : n[i];
            len2 = len2 + m[i] * m[i];
        end
        if (len2 == 0) begin
            r = '{0, 0, 0, 1'b1};
        end else begin
            for (int i = 0; i < 3; i++) begin
                q[i] = scaled_mag(m[i], len2);
                if (n[i] < 0) q[i] = -q[i];
            end
            r = '{q[0], q[1], q[2], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? CMAX : CMIN;
            1, 2: return CW'($signed($urandom_range(0, 64)) - 32);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic tri_t rand_triangle();
        tri_t v;
        int k;
        for (int i = 0; i < 9; i++) v[i] = rand_coord();
        case ($urandom_range(0, 9))
            0: for (int i = 0; i < 3; i++) v[6+i] = v[i];
            1: for (int i = 0; i < 3; i++) v[3+i] = v[3+i] == v[i] ? v[3+i] : v[i];
            2: begin
                // collinear from small edges
                k = $urandom_range(0, 6) - 3;
                for (int i = 0; i < 3; i++) begin
                    v[i] = CW'($signed($urandom_range(0, 2000)) - 1000);
                    v[3+i] = v[i] + CW'($signed($urandom_range(0, 200)) - 100);
                    v[6+i] = v[i] + CW'(k * ($signed(v[3+i]) - $signed(v[i])));
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // receiver: stall a random count after each word, long stretches with none
    always @(negedge i_clk) begin
        if (took_word) begin
            took_word <= 1'b0;
            stall_left = no_idle ? 0 : $urandom_range(0, 16);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            took_word <= 1'b1;
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected word nx=%0d ny=%0d nz=%0d degen=%0b",
                         $time, o_nx, o_ny, o_nz, o_degenerate);
                errors++;
            end else begin
                want = pending_normals.pop_front();
                if (o_nx !== want.nx || o_ny !== want.ny || o_nz !== want.nz
                        || o_degenerate !== want.degen) begin
                    $display("%0t: expected nx=%0d ny=%0d nz=%0d degen=%0b", $time,
                             want.nx, want.ny, want.nz, want.degen);
                    $display("%0t: actual   nx=%0d ny=%0d nz=%0d degen=%0b", $time,
                             o_nx, o_ny, o_nz, o_degenerate);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(tri_t v, normal_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        vin <= v;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_normals.push_back(want);
        @(negedge i_clk);
    endtask

    row_t rows[$];

    initial begin
        row_t r;
        normal_t want;
        // all-zero and coincident vertices give the degenerate flag
        rows.push_back('{'0, 1'b1, '{0, 0, 0, 1'b1}});
        rows.push_back('{{9{CMAX}}, 1'b1, '{0, 0, 0, 1'b1}});
        rows.push_back('{{9{CMIN}}, 1'b1, '{0, 0, 0, 1'b1}});
        // axis-aligned triangles, unit-sized and full-range
        rows.push_back('{{CW'(0), CW'(0), CW'(0), CW'(1), CW'(0), CW'(0),
                          CW'(0), CW'(1), CW'(0)}, 1'b1, '{0, 0, UNIT, 1'b0}});
        rows.push_back('{{CW'(0), CW'(0), CW'(0), CW'(0), CW'(1), CW'(0),
                          CW'(1), CW'(0), CW'(0)}, 1'b1, '{0, 0, -UNIT, 1'b0}});
        rows.push_back('{{CW'(0), CW'(0), CW'(0), CW'(0), CW'(1), CW'(0),
                          CW'(0), CW'(0), CW'(1)}, 1'b1, '{UNIT, 0, 0, 1'b0}});
        rows.push_back('{{CW'(0), CW'(0), CW'(0), CW'(0), CW'(0), CW'(1),
                          CW'(1), CW'(0), CW'(0)}, 1'b1, '{0, UNIT, 0, 1'b0}});
        rows.push_back('{{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN,
                          CMIN, CMAX, CMIN}, 1'b1, '{0, 0, UNIT, 1'b0}});
        // extremes and skewed shapes, checked by prediction where no result is known
        rows.push_back('{{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN,
                          CMIN, CMAX, CMAX}, 1'b0, '{0, 0, 0, 1'b0}});
        rows.push_back('{{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN,
                          CMAX, CMAX, CMIN}, 1'b0, '{0, 0, 0, 1'b0}});
        rows.push_back('{{CW'(0), CW'(0), CW'(0), CW'(1), CW'(1), CW'(1),
                          CW'(1), CW'(2), CW'(3)}, 1'b0, '{0, 0, 0, 1'b0}});
        rows.push_back('{{CW'(0), CW'(0), CW'(0), CMAX, CW'(0), CW'(0),
                          CMAX, CW'(1), CW'(0)}, 1'b0, '{0, 0, 0, 1'b0}});
        rows.push_back('{{CW'(5), CW'(5), CW'(5), CW'(6), CW'(6), CW'(6),
                          CW'(8), CW'(8), CW'(8)}, 1'b1, '{0, 0, 0, 1'b1}});
        rows.push_back('{{CW'(-1), CW'(-1), CW'(-1), CW'(1), CW'(-1), CW'(-1),
                          CW'(-1), CW'(1), CW'(-1)}, 1'b1, '{0, 0, UNIT, 1'b0}});
        rows.push_back('{{CW'(0), CW'(0), CW'(0), CW'(3), CW'(0), CW'(0),
                          CW'(0), CW'(3), CW'(1)}, 1'b0, '{0, 0, 0, 1'b0}});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            r = rows[i];
            send_word(r.v, r.known ? r.res : face_normal(r.v));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 250 == 0) no_idle = ($urandom_range(0, 2) == 0);
            r.v = rand_triangle();
            want = face_normal(r.v);
            send_word(r.v, want);
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
